[rtl/core/descending_sorted_list_store_assert.svh]
// assertion macros for the descending sorted list store
`ifndef DESCENDING_SORTED_LIST_STORE_ASSERT_SVH
`define DESCENDING_SORTED_LIST_STORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DSLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsls assertion failed");

// next-cycle implication, disabled while in reset
`define DSLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsls assertion failed");

`endif

[rtl/core/dsls_pkg.sv]
// shared types and codes for the descending sorted list store
`default_nettype none

package dsls_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_READ   = 2'd2;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_FULL   = 2'd1;
    localparam t_status ST_EMPTY  = 2'd2;
    localparam t_status ST_BADIDX = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic cap;        // capture a new operation
        logic ins_init;   // hole at count, read the last entry
        logic ins_step;   // move smaller entry up, hole down
        logic ins_fin;    // write value into the hole
        logic rm_init;    // pointer to index, read it
        logic keep_data;  // latch read data as result data
        logic rd_next;    // read the entry after the pointer
        logic rm_step;    // move entry down, pointer up
        logic finish;     // update count and present the result
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_status chk;       // outcome of the full/empty/index checks
        logic    op_ins;
        logic    op_rm;
        logic    cnt_zero;
        logic    hole_one;
        logic    smaller;   // read entry is below the inserted value
        logic    more1;     // pointer + 1 below count
        logic    more2;     // pointer + 2 below count
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/dsls_dpath.sv]
// datapath: entry memory, count, pointer and result registers
`default_nettype none

module dsls_dpath
    import dsls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_op                i_op,
    input  wire logic signed [31:0] i_value,
    input  wire logic        [6:0]  i_index,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    output logic                    o_valid,
    output t_status                 o_status,
    output logic signed [31:0]      o_data,
    output logic        [6:0]       o_count,
    output logic                    o_is_full,
    output logic                    o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    logic [31:0]   mem [CAPACITY];

    t_op           r_op;
    logic [31:0]   r_value;
    logic [6:0]    r_index;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] n_ptr;
    logic [31:0]   r_rdata;
    logic [31:0]   r_data;

    logic          r_valid;
    t_status       r_status;
    logic [31:0]   r_o_data;
    logic [6:0]    r_o_count;
    logic          r_full;
    logic          r_empty;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] ncnt_x;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] ptr_m2;
    logic [CW:0]   ptr_p1;
    logic [CW:0]   ptr_p2;
    t_status       chk;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // arithmetic helpers
    always_comb begin
        cnt_x  = XW'(r_count);
        idx_x  = XW'(r_index);
        cnt_m1 = r_count - CW'(1);
        ptr_m2 = r_ptr - CW'(2);
        ptr_p1 = {1'b0, r_ptr} + (CW+1)'(1);
        ptr_p2 = {1'b0, r_ptr} + (CW+1)'(2);
    end

    // full, empty and index checks in the fixed order
    always_comb begin
        unique case (r_op)
            OP_INSERT: begin
                if (cnt_x == XW'(CAPACITY)) begin
                    chk = ST_FULL;
                end else if (idx_x > cnt_x) begin
                    chk = ST_BADIDX;
                end else begin
                    chk = ST_OK;
                end
            end
            OP_REMOVE, OP_READ: begin
                if (r_count == '0) begin
                    chk = ST_EMPTY;
                end else if (idx_x >= cnt_x) begin
                    chk = ST_BADIDX;
                end else begin
                    chk = ST_OK;
                end
            end
            default: chk = ST_BADIDX;
        endcase
    end

    // status to the controller
    always_comb begin
        o_stat.chk      = chk;
        o_stat.op_ins   = (r_op == OP_INSERT);
        o_stat.op_rm    = (r_op == OP_REMOVE);
        o_stat.cnt_zero = (r_count == '0);
        o_stat.hole_one = (r_ptr == CW'(1));
        o_stat.smaller  = ($signed(r_rdata) < $signed(r_value));
        o_stat.more1    = (ptr_p1 < {1'b0, r_count});
        o_stat.more2    = (ptr_p2 < {1'b0, r_count});
    end

    // memory port and pointer control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_ptr[AW-1:0];
        wr_data = r_rdata;
        n_ptr   = r_ptr;
        if (i_cmd.ins_init) begin
            n_ptr   = r_count;
            rd_en   = (r_count != '0);
            rd_addr = cnt_m1[AW-1:0];
        end
        if (i_cmd.ins_step) begin
            wr_en   = 1'b1;
            n_ptr   = r_ptr - CW'(1);
            rd_en   = (r_ptr != CW'(1));
            rd_addr = ptr_m2[AW-1:0];
        end
        if (i_cmd.ins_fin) begin
            wr_en   = 1'b1;
            wr_data = r_value;
        end
        if (i_cmd.rm_init) begin
            n_ptr   = idx_x[CW-1:0];
            rd_en   = 1'b1;
            rd_addr = idx_x[AW-1:0];
        end
        if (i_cmd.rd_next) begin
            rd_en   = 1'b1;
            rd_addr = ptr_p1[AW-1:0];
        end
        if (i_cmd.rm_step) begin
            wr_en   = 1'b1;
            n_ptr   = ptr_p1[CW-1:0];
            rd_en   = o_stat.more2;
            rd_addr = ptr_p2[AW-1:0];
        end
    end

    // count after the operation
    always_comb begin
        n_count = r_count;
        if (chk == ST_OK && r_op == OP_INSERT) begin
            n_count = r_count + CW'(1);
        end else if (chk == ST_OK && r_op == OP_REMOVE) begin
            n_count = r_count - CW'(1);
        end
        ncnt_x = XW'(n_count);
    end

    // entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // operation and result payload
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.cap) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_index <= i_index;
            r_data  <= '0;
        end else if (i_cmd.keep_data) begin
            r_data <= r_rdata;
        end
        if (i_cmd.finish) begin
            r_status  <= chk;
            // entry read in the finishing cycle goes straight to the result
            r_o_data  <= i_cmd.keep_data ? r_rdata : r_data;
            r_o_count <= ncnt_x[6:0];
            r_full    <= (ncnt_x == XW'(CAPACITY));
            r_empty   <= (n_count == '0);
        end
    end

    // count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data     = r_o_data;
    assign o_count    = r_o_count;
    assign o_is_full  = r_full;
    assign o_is_empty = r_empty;

endmodule

`default_nettype wire

[rtl/core/dsls_ctrl.sv]
// controller state machine sequencing the memory walks
`default_nettype none

module dsls_ctrl
    import dsls_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_INS_CMP  = 3'd2;
    localparam logic [2:0] S_INS_FIN  = 3'd3;
    localparam logic [2:0] S_RM_FIRST = 3'd4;
    localparam logic [2:0] S_RM_SHIFT = 3'd5;
    localparam logic [2:0] S_RD_DATA  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.chk != ST_OK) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.op_ins) begin
                    o_cmd.ins_init = 1'b1;
                    n_state        = i_stat.cnt_zero ? S_INS_FIN : S_INS_CMP;
                end else begin
                    o_cmd.rm_init = 1'b1;
                    n_state       = i_stat.op_rm ? S_RM_FIRST : S_RD_DATA;
                end
            end
            S_INS_CMP: begin
                if (i_stat.smaller) begin
                    o_cmd.ins_step = 1'b1;
                    n_state        = i_stat.hole_one ? S_INS_FIN : S_INS_CMP;
                end else begin
                    n_state = S_INS_FIN;
                end
            end
            S_INS_FIN: begin
                o_cmd.ins_fin = 1'b1;
                o_cmd.finish  = 1'b1;
                n_state       = S_IDLE;
            end
            S_RM_FIRST: begin
                o_cmd.keep_data = 1'b1;
                if (i_stat.more1) begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_RM_SHIFT;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RM_SHIFT: begin
                o_cmd.rm_step = 1'b1;
                if (!i_stat.more2) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD_DATA: begin
                o_cmd.keep_data = 1'b1;
                o_cmd.finish    = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/descending_sorted_list_store.sv]
// Sorted list store: one operation at a time, busy high from the transfer until the result.
// Reads pass through the check and read-data states before the result strobe, and failed
// operations finish from the check state. Remove shifts the entries after the index down and
// insert shifts smaller entries up, one entry per cycle, via the memory's read and write ports.
// Synchronous active-low reset empties the list; entry memory is not cleared.
// The strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none

`include "descending_sorted_list_store_assert.svh"

module descending_sorted_list_store
    import dsls_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  i_op,
    input  wire logic signed [31:0] i_value,
    input  wire logic        [6:0]  i_index,
    output logic                    o_valid,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_data,
    output logic             [6:0]  o_count,
    output logic                    o_is_full,
    output logic                    o_is_empty
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing
    dsls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    // storage and result
    dsls_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_index    (i_index),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_count    (o_count),
        .o_is_full  (o_is_full),
        .o_is_empty (o_is_empty)
    );

    // an accepted transfer always starts work
    `DSLS_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // the result comes out only once the controller is back to idle
    `DSLS_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy && $past(busy))
    // the result strobe is a single cycle
    `DSLS_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

`default_nettype wire
